@@ rtl/lbts_time_barrier_top_defines.svh @@
// Assertion macros for the LBTS time barrier block.
`ifndef LBTS_TIME_BARRIER_TOP_DEFINES_SVH
`define LBTS_TIME_BARRIER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LBTS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lbts assertion failed");

// Next-cycle implication, checked out of reset.
`define LBTS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lbts assertion failed");

`endif

@@ rtl/lbts_pkg.sv @@
// Package: types and constants shared by the LBTS time barrier modules.
`timescale 1ns / 1ps
package lbts_pkg;

    localparam int TIME_W = 64;
    localparam int CNT_W  = 5;
    localparam int PART_W = 4;
    localparam int CFG_W  = 5;

    typedef enum logic [1:0] {
        CMD_REQUEST = 2'd0,
        CMD_LEAVE   = 2'd1,
        CMD_ADVANCE = 2'd2,
        CMD_QUERY   = 2'd3
    } cmd_t;

    localparam logic REG_TOTAL = 1'b0;
    localparam logic REG_OWN   = 1'b1;

    typedef struct packed {
        logic              lt;
        logic [TIME_W-1:0] sum;
    } alu_res_t;

endpackage

@@ rtl/lbts_time_barrier_top.sv @@
// Top level: LBTS time barrier with slot table, sequencer and shared compare unit.
`timescale 1ns / 1ps
//  channel   dir  signals                      content
//  s_axis    in   s_tvalid s_tready s_tdata    cmd, participant, time_value
//  m_axis    out  m_tvalid m_tready m_tdata    lbts, time_granted, counts
//  cfg       in   cfg_we cfg_index cfg_data    total_participants, own_slot
//
//  Query goes straight to the grant step. Other commands run read, update, a scan
//  of min(MAX_PARTICIPANTS,16) slots through the single RAM read port and the one
//  comparator, then bound and grant. Reset clears valid marks, sets LBTS to -1.
//  A result waits in the output register; the next word is taken meanwhile,
//  and the sequencer holds in its last step only while that register is full.
`include "lbts_time_barrier_top_defines.svh"
module lbts_time_barrier_top
    import lbts_pkg::*;
#(
    parameter int MAX_PARTICIPANTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // cmd[1:0], participant[5:2], time_value[69:6]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // lbts[63:0], time_granted[64],
                                   // reported_count[69:65], active_count[74:70]
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    localparam int SLOTS = (MAX_PARTICIPANTS < 16) ? MAX_PARTICIPANTS : 16;
    localparam int IW    = $clog2(SLOTS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_SCAN,
        S_BOUND,
        S_GRANT
    } state_t;

    state_t            state_reg;
    cmd_t              cmd_reg;
    logic [PART_W-1:0] part_reg;
    logic [TIME_W-1:0] tv_reg;
    logic [PART_W-1:0] own_reg;
    logic [CNT_W-1:0]  left_reg;
    logic [TIME_W-1:0] bound_reg;
    logic [SLOTS-1:0]  valid_reg;
    logic [TIME_W-1:0] min_reg;
    logic              found_reg;
    logic [IW:0]       cnt_reg;
    logic [IW-1:0]     rd_idx_reg;
    logic              rd_pend_reg;
    logic              out_valid_reg;
    logic [TIME_W-1:0] out_lbts_reg;
    logic              out_grant_reg;
    logic [CNT_W-1:0]  out_rep_reg;
    logic [CNT_W-1:0]  out_act_reg;

    logic [PART_W-1:0] slot_sel;
    logic [IW-1:0]     slot_idx;
    logic              slot_in_rng;
    logic [CNT_W-1:0]  rep_count;
    logic              in_accept;
    logic              out_load;
    logic              upd_store;
    logic              scan_take;

    logic              ram_we;
    logic [IW-1:0]     ram_raddr;
    logic [TIME_W-1:0] ram_wdata;
    logic [TIME_W-1:0] ram_rdata;
    logic [TIME_W-1:0] alu_a;
    logic [TIME_W-1:0] alu_b;
    alu_res_t          alu_res;

    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {5'd0, out_act_reg, out_rep_reg, out_grant_reg, out_lbts_reg};

    assign slot_sel    = (cmd_reg == CMD_ADVANCE) ? own_reg : part_reg;
    assign slot_idx    = slot_sel[IW-1:0];
    assign slot_in_rng = 32'(slot_sel) < MAX_PARTICIPANTS;
    assign rep_count   = CNT_W'($countones(valid_reg));
    assign out_load    = (state_reg == S_GRANT) && (!out_valid_reg || m_tready);

    always_comb
    begin
        alu_a = bound_reg;
        alu_b = tv_reg;
        case (state_reg)
            S_UPDATE:
            begin
                alu_a = (cmd_reg == CMD_ADVANCE) ? bound_reg : ram_rdata;
                alu_b = tv_reg;
            end
            S_SCAN:
            begin
                alu_a = ram_rdata;
                alu_b = min_reg;
            end
            S_BOUND:
            begin
                alu_a = bound_reg;
                alu_b = min_reg;
            end
            default:
            begin
                alu_a = bound_reg;
                alu_b = tv_reg;
            end
        endcase
    end

    assign upd_store = slot_in_rng &&
                       ((cmd_reg == CMD_ADVANCE) ||
                        ((cmd_reg == CMD_REQUEST) && (!valid_reg[slot_idx] || alu_res.lt)));
    assign ram_we    = (state_reg == S_UPDATE) && upd_store;
    assign ram_wdata = (cmd_reg == CMD_ADVANCE) ? alu_res.sum : tv_reg;
    assign ram_raddr = (state_reg == S_SCAN) ? cnt_reg[IW-1:0] : slot_idx;
    assign scan_take = rd_pend_reg && valid_reg[rd_idx_reg] && (!found_reg || alu_res.lt);

    lbts_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    lbts_ram #(
        .WIDTH (TIME_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_idx),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cmd_reg       <= CMD_QUERY;
            own_reg       <= '0;
            left_reg      <= '0;
            bound_reg     <= '1;
            valid_reg     <= '0;
            found_reg     <= 1'b0;
            cnt_reg       <= '0;
            rd_idx_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_TOTAL)
                begin
                    left_reg <= cfg_data;
                end
                else
                begin
                    own_reg <= cfg_data[PART_W-1:0];
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        cmd_reg   <= cmd_t'(s_tdata[1:0]);
                        state_reg <= (cmd_t'(s_tdata[1:0]) == CMD_QUERY) ? S_GRANT : S_READ;
                    end
                end
                S_READ:
                begin
                    state_reg <= S_UPDATE;
                end
                S_UPDATE:
                begin
                    if (cmd_reg == CMD_LEAVE)
                    begin
                        if (left_reg != '0)
                        begin
                            left_reg <= left_reg - CNT_W'(1);
                        end
                        if (slot_in_rng)
                        begin
                            valid_reg[slot_idx] <= 1'b0;
                        end
                    end
                    else if (upd_store)
                    begin
                        valid_reg[slot_idx] <= 1'b1;
                    end
                    found_reg   <= 1'b0;
                    cnt_reg     <= '0;
                    rd_pend_reg <= 1'b0;
                    state_reg   <= S_SCAN;
                end
                S_SCAN:
                begin
                    if (scan_take)
                    begin
                        found_reg <= 1'b1;
                    end
                    rd_pend_reg <= (cnt_reg < (IW+1)'(SLOTS));
                    rd_idx_reg  <= cnt_reg[IW-1:0];
                    cnt_reg     <= cnt_reg + (IW+1)'(1);
                    if (cnt_reg == (IW+1)'(SLOTS))
                    begin
                        state_reg <= S_BOUND;
                    end
                end
                S_BOUND:
                begin
                    if (found_reg && alu_res.lt && (rep_count == left_reg))
                    begin
                        bound_reg <= min_reg;
                    end
                    state_reg <= S_GRANT;
                end
                S_GRANT:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            part_reg <= s_tdata[5:2];
            tv_reg   <= s_tdata[69:6];
        end
        else if ((state_reg == S_UPDATE) && (cmd_reg == CMD_ADVANCE))
        begin
            tv_reg <= alu_res.sum;
        end
        if ((state_reg == S_SCAN) && scan_take)
        begin
            min_reg <= ram_rdata;
        end
        if (out_load)
        begin
            out_lbts_reg  <= bound_reg;
            out_grant_reg <= (cmd_reg != CMD_LEAVE) && !alu_res.lt;
            out_rep_reg   <= rep_count;
            out_act_reg   <= left_reg;
        end
    end

    `LBTS_ASSERT_NEXT(a_work_leaves_idle,
        in_accept && (s_tdata[1:0] != CMD_QUERY), state_reg == S_READ)
    `LBTS_ASSERT_NEXT(a_bound_monotonic, 1'b1,
        $signed(bound_reg) >= $signed($past(bound_reg)))
    `LBTS_ASSERT_NEXT(a_left_only_on_leave,
        !cfg_we && !((state_reg == S_UPDATE) && (cmd_reg == CMD_LEAVE)), $stable(left_reg))
    `LBTS_ASSERT_NOW(a_count_in_range, 1'b1, rep_count <= CNT_W'(SLOTS))

endmodule

@@ rtl/lbts_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lbts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/lbts_alu.sv @@
// Shared unit: signed less-than compare and saturating signed add.
`timescale 1ns / 1ps
module lbts_alu
    import lbts_pkg::*;
(
    input  logic [TIME_W-1:0] a,
    input  logic [TIME_W-1:0] b,
    output alu_res_t          res
);

    logic [TIME_W-1:0] raw_sum;
    logic              ovf;

    assign raw_sum = a + b;
    assign ovf     = (a[TIME_W-1] == b[TIME_W-1]) && (raw_sum[TIME_W-1] != a[TIME_W-1]);

    assign res.lt  = $signed(a) < $signed(b);
    assign res.sum = !ovf ? raw_sum :
                     a[TIME_W-1] ? {1'b1, {(TIME_W-1){1'b0}}} : {1'b0, {(TIME_W-1){1'b1}}};

endmodule

@@ verif/tb.sv @@
// Testbench for lbts_time_barrier_top: directed and random stimulus, scoreboard check.
`timescale 1ns / 1ps
module tb;
    import lbts_pkg::*;

    localparam int SLOTS         = 16;
    localparam int SETTLE_CYCLES = 30;
    localparam int HOLD_CYCLES   = 300;
    localparam logic signed [63:0] T_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] T_MIN = 64'sh8000_0000_0000_0000;

    // packed so that lbts sits in the low bits, as on m_tdata
    typedef struct packed {
        logic [4:0]  active;
        logic [4:0]  reported;
        logic        granted;
        logic [63:0] lbts;
    } barrier_out_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;     // cmd[1:0], participant[5:2], time_value[69:6]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;          // lbts[63:0], time_granted[64],
                                   // reported_count[69:65], active_count[74:70]
    logic        cfg_we = 1'b0;
    logic        cfg_index = 1'b0;
    logic [CFG_W-1:0] cfg_data = '0;

    // predictor state
    logic signed [63:0] slot_t [SLOTS];
    logic [SLOTS-1:0]   slot_ok = '0;
    logic signed [63:0] bound_t = -64'sd1;
    logic [4:0]         left_q = '0;
    logic [3:0]         own_q = '0;

    barrier_out_t lbts_expected[$];
    int mismatches = 0;
    bit idle_en = 1'b1;
    int hold_seq = 0;

    lbts_time_barrier_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic void refresh_bound();
        logic found;
        logic signed [63:0] lo;
        found = 1'b0;
        lo = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (slot_ok[i] && (!found || slot_t[i] < lo))
            begin
                lo = slot_t[i];
                found = 1'b1;
            end
        end
        if (found && bound_t < lo && $countones(slot_ok) == int'(left_q))
            bound_t = lo;
    endfunction

    function automatic barrier_out_t barrier_predict(cmd_t c, logic [3:0] p,
                                                     logic signed [63:0] tv);
        barrier_out_t r;
        logic signed [63:0] target;
        logic [64:0] wide;
        r = '0;
        case (c)
            CMD_REQUEST:
            begin
                if (!slot_ok[p] || slot_t[p] < tv)
                begin
                    slot_t[p] = tv;
                    slot_ok[p] = 1'b1;
                end
                refresh_bound();
                r.granted = (bound_t >= tv);
            end
            CMD_LEAVE:
            begin
                if (left_q != 0)
                    left_q = left_q - 5'd1;
                slot_ok[p] = 1'b0;
                refresh_bound();
                r.granted = 1'b0;
            end
            CMD_ADVANCE:
            begin
                wide = {bound_t[63], bound_t} + {tv[63], tv};
                if (wide[64] != wide[63])
                    target = wide[64] ? T_MIN : T_MAX;
                else
                    target = wide[63:0];
                slot_t[own_q] = target;
                slot_ok[own_q] = 1'b1;
                refresh_bound();
                r.granted = (bound_t >= target);
            end
            default:
                r.granted = (bound_t >= tv);
        endcase
        r.lbts = bound_t;
        r.reported = 5'($countones(slot_ok));
        r.active = left_q;
        return r;
    endfunction

    function automatic void check_field(string what, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t %s expected %0h actual %0h", $time, what, want, got);
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        barrier_out_t want;
        barrier_out_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = barrier_out_t'(m_tdata[74:0]);
            if (lbts_expected.size() == 0)
            begin
                mismatches++;
                $display("%0t unexpected word expected none actual %0h", $time, got);
            end
            else
            begin
                want = lbts_expected.pop_front();
                check_field("lbts", want.lbts, got.lbts);
                check_field("time_granted", want.granted, got.granted);
                check_field("reported_count", want.reported, got.reported);
                check_field("active_count", want.active, got.active);
            end
        end
    end

    // receiver: random stalls, plus a long hold-off each time hold_seq moves
    initial
    begin : receiver
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        forever
        begin
            @(negedge clk);
            if (hold_seen != hold_seq)
            begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready = 1'b0;
            end
            else
                m_tready = !(idle_en && $urandom_range(99) < 38);
        end
    end

    task automatic send_word(input cmd_t c, input logic [3:0] p,
                             input logic signed [63:0] tv);
        while (idle_en && $urandom_range(99) < 38)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = {2'b00, tv, p, c};
        do
            @(posedge clk);
        while (!s_tready);
        lbts_expected.insert(lbts_expected.size(), barrier_predict(c, p, tv));
        @(negedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (lbts_expected.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [4:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(posedge clk);
        if (idx == REG_TOTAL)
            left_q = val;
        else
            own_q = val[3:0];
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic signed [63:0] pick_time(int spread);
        logic signed [63:0] off;
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return {$urandom, $urandom};
        if (r < 11)
            return T_MAX;
        if (r < 14)
            return T_MIN;
        off = 64'($urandom_range(spread));
        return bound_t + off - 64'sd200;
    endfunction

    task automatic test_directed_cases();
        // reset defaults: no participants, own slot 0
        send_word(CMD_QUERY, 4'd0, T_MIN);
        send_word(CMD_QUERY, 4'd0, T_MAX);
        send_word(CMD_QUERY, 4'd0, -64'sd1);
        send_word(CMD_LEAVE, 4'd0, 64'sd0);          // empty table, count saturates
        send_word(CMD_ADVANCE, 4'd0, T_MIN);         // negative saturation
        send_word(CMD_LEAVE, 4'd0, 64'sd0);
        wait_idle();
        cfg_write(REG_TOTAL, 5'd2);
        cfg_write(REG_OWN, 5'd15);
        send_word(CMD_REQUEST, 4'd0, 64'sd100);
        send_word(CMD_REQUEST, 4'd0, 64'sd50);       // smaller time is dropped
        send_word(CMD_REQUEST, 4'd1, 64'sd200);      // all reported, bound rises
        send_word(CMD_QUERY, 4'd0, 64'sd100);
        send_word(CMD_QUERY, 4'd0, 64'sd101);
        send_word(CMD_ADVANCE, 4'd0, T_MAX);         // positive saturation
        send_word(CMD_LEAVE, 4'd15, 64'sd0);
        send_word(CMD_LEAVE, 4'd1, 64'sd0);
        send_word(CMD_LEAVE, 4'd1, 64'sd0);          // slot already empty, count stays at zero
        send_word(CMD_REQUEST, 4'd15, T_MAX);
        wait_idle();
        cfg_write(REG_TOTAL, 5'd1);
        cfg_write(REG_OWN, 5'd0);
        send_word(CMD_LEAVE, 4'd15, 64'sd0);
        send_word(CMD_ADVANCE, 4'd0, 64'sd5);
        send_word(CMD_ADVANCE, 4'd0, -64'sd50);      // own slot overwritten lower
        send_word(CMD_REQUEST, 4'd0, T_MIN);
        send_word(CMD_QUERY, 4'd0, T_MIN);
        wait_idle();
    endtask

    task automatic test_random_traffic(input logic [4:0] total, input logic [3:0] own,
                                       input int count);
        int r;
        cmd_t c;
        logic [3:0] p;
        logic signed [63:0] tv;
        cfg_write(REG_TOTAL, total);
        cfg_write(REG_OWN, {1'b0, own});
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(99);
            if (r < 62)
                c = CMD_REQUEST;
            else if (r < 76)
                c = CMD_ADVANCE;
            else if (r < 94)
                c = CMD_QUERY;
            else
                c = CMD_LEAVE;
            if (total != 0 && total <= SLOTS && $urandom_range(99) < 85)
                p = 4'($urandom_range(int'(total) - 1));
            else
                p = 4'($urandom_range(SLOTS - 1));
            if (c == CMD_ADVANCE && $urandom_range(99) < 80)
                tv = $signed(64'($urandom_range(400))) - 64'sd50;
            else
                tv = pick_time(2000);
            send_word(c, p, tv);
        end
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        hold_seq++;
        test_random_traffic(5'd4, 4'd3, 60);
    endtask

    task automatic test_no_idle_stream();
        idle_en = 1'b0;
        test_random_traffic(5'd3, 4'd2, 150);
        idle_en = 1'b1;
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed_cases();
        test_random_traffic(5'd1, 4'd0, 200);
        test_random_traffic(5'd2, 4'd5, 200);
        test_random_traffic(5'd16, 4'd15, 220);
        test_random_traffic(5'd31, 4'd3, 120);       // count can never be reached
        test_random_traffic(5'd0, 4'd7, 120);
        test_output_backpressure();
        test_random_traffic(5'd4, 4'($urandom_range(15)), 200);
        test_no_idle_stream();
        test_random_traffic(5'd8, 4'($urandom_range(15)), 200);
        test_random_traffic(5'd16, 4'd0, 150);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/lbts_pkg.sv
rtl/lbts_ram.sv
rtl/lbts_alu.sv
rtl/lbts_time_barrier_top.sv
verif/tb.sv
